// ----- hdl/logit_bias_steer_mask_engine_top_macros.svh -----
// Assertion macros for the logit bias, steering and mask engine.
`ifndef LOGIT_BIAS_STEER_MASK_ENGINE_TOP_MACROS_SVH
`define LOGIT_BIAS_STEER_MASK_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LBSM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("lbsm check failed");
`define LBSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbsm check failed");
`else
`define LBSM_ASSERT(lbl, prop)
`define LBSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/lbsm_pkg.sv -----
// Shared types and constants of the logit bias, steering and mask engine.
`default_nettype none
package lbsm_pkg;
	localparam int VOCAB_DEPTH_DEF = 32768;
	localparam int POS_W = 15;
	localparam int VAL_W = 32;
	localparam int STEER_W = 16;
	localparam int CFG_W = 16;
	localparam int BIAS_W = 2 * VAL_W;
	localparam int AUX_W = STEER_W + 2;
	localparam logic signed [VAL_W-1:0] NEG_INF = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};

	localparam logic [3:0] FN_LOGIT     = 4'd0;
	localparam logic [3:0] FN_PERS      = 4'd1;
	localparam logic [3:0] FN_PEND      = 4'd2;
	localparam logic [3:0] FN_CLR_BIAS  = 4'd3;
	localparam logic [3:0] FN_CLR_PEND  = 4'd4;
	localparam logic [3:0] FN_STEER     = 4'd5;
	localparam logic [3:0] FN_CLR_STEER = 4'd6;
	localparam logic [3:0] FN_TOK       = 4'd7;
	localparam logic [3:0] FN_CLR_TOK   = 4'd8;
	localparam logic [3:0] FN_SYN       = 4'd9;
	localparam logic [3:0] FN_CLR_SYN   = 4'd10;

	localparam logic REG_VOCAB    = 1'b0;
	localparam logic REG_STRENGTH = 1'b1;

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_READ, ST_ADD1, ST_ADD2, ST_FIN
	} state_t;

	// fields wiped by a sweep
	typedef struct packed {
		logic pers;
		logic pend;
		logic steer;
		logic tok;
		logic syn;
	} clr_t;
endpackage
`default_nettype wire

// ----- hdl/lbsm_mem.sv -----
// Single-port-write, registered-read memory for the per-token stores.
`default_nettype none
module lbsm_mem #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/lbsm_alu.sv -----
// Saturating Q16.16 adder with minus-infinity propagation.
`default_nettype none
module lbsm_alu (
	input  wire logic signed [lbsm_pkg::VAL_W-1:0] a,
	input  wire logic signed [lbsm_pkg::VAL_W-1:0] b,
	output logic      signed [lbsm_pkg::VAL_W-1:0] sum
);
	import lbsm_pkg::*;

	logic signed [VAL_W:0] raw;

	assign raw = (VAL_W+1)'(a) + (VAL_W+1)'(b);

	always_comb begin
		if (a == NEG_INF || b == NEG_INF) begin
			sum = NEG_INF;
		end else if (raw > (VAL_W+1)'(POS_MAX)) begin
			sum = POS_MAX;
		end else if (raw < (VAL_W+1)'(NEG_MIN)) begin
			sum = NEG_MIN;
		end else begin
			sum = VAL_W'(raw);
		end
	end
endmodule
`default_nettype wire

// ----- hdl/logit_bias_steer_mask_engine_top.sv -----
// Top level of the logit bias, steering and mask engine.
`default_nettype none
`include "logit_bias_steer_mask_engine_top_macros.svh"
// One item is handled at a time. An item passes through the accept
// cycle, a memory read, and three steps through the one shared saturating
// adder. Its write-back lands at the end of the last of these, and the next
// item can be accepted in the cycle after. A logit result then waits in an
// output register that the next item does not block. A logit reaching its
// last step while that register is still full stalls there until the
// register drains. The per-token stores sit in two memories (biases;
// steering value plus both allow bits) and every update is a read-modify-write
// of one entry. Clear items, and a logit flagged last (which drops the pending
// biases), start a sweep that rewrites every entry; no item is accepted
// during it. The same sweep runs once after reset, and in_ready first
// rises when that sweep ends. Configuration writes are always taken.
module logit_bias_steer_mask_engine_top #(
	parameter int VOCAB_DEPTH = lbsm_pkg::VOCAB_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic                                cfg_index,
	input  wire logic        [lbsm_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic        [3:0]                   func,
	input  wire logic        [lbsm_pkg::POS_W-1:0]   position,
	input  wire logic signed [lbsm_pkg::VAL_W-1:0]   item_value,
	input  wire logic signed [lbsm_pkg::STEER_W-1:0] steer_value,
	input  wire logic                                last_in,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic             [lbsm_pkg::POS_W-1:0]   position_out,
	output logic signed      [lbsm_pkg::VAL_W-1:0]   logit_out,
	output logic                                     masked_out,
	output logic                                     last_out
);
	import lbsm_pkg::*;

	localparam int AW = $clog2(VOCAB_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] CNT_END = CW'(VOCAB_DEPTH);

	state_t state_q, state_d;

	// config and flags
	logic [CFG_W-1:0]          vocab_q;
	logic signed [CFG_W-1:0]   strength_q;
	logic [STEER_W-1:0]        steer_len_q;
	logic                      steer_on_q, tok_on_q, syn_on_q;

	// item held while it is worked on
	logic [3:0]                func_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [VAL_W-1:0]   val_q;
	logic signed [STEER_W-1:0] steer_q;
	logic                      last_q, inr_q, hit_q;

	logic signed [VAL_W-1:0]   acc_q, prod_q, term_q;

	// sweep
	clr_t                      clr_q;
	logic [CW-1:0]             cnt_q;
	logic [AW-1:0]             addr_s1;
	logic                      wr_s1;

	// output register
	logic                      out_valid_q;

	// memories
	logic                      mem_re, bias_we, aux_we;
	logic [AW-1:0]             mem_raddr, mem_waddr, pos_addr;
	logic [BIAS_W-1:0]         bias_rd, bias_wd;
	logic [AUX_W-1:0]          aux_rd, aux_wd;

	logic signed [VAL_W-1:0]   alu_a, alu_b, alu_sum;
	logic                      accept, fin_go, need_clr, rd_en, mask_hit, clr_start;
	logic signed [VAL_W:0]     term_raw;
	logic signed [VAL_W-1:0]   fin_val;
	clr_t                      clr_d;

	lbsm_mem #(.WIDTH(BIAS_W), .DEPTH(VOCAB_DEPTH)) u_bias_mem (
		.clk(clk), .we(bias_we), .waddr(mem_waddr), .wdata(bias_wd),
		.re(mem_re), .raddr(mem_raddr), .rdata(bias_rd)
	);

	lbsm_mem #(.WIDTH(AUX_W), .DEPTH(VOCAB_DEPTH)) u_aux_mem (
		.clk(clk), .we(aux_we), .waddr(mem_waddr), .wdata(aux_wd),
		.re(mem_re), .raddr(mem_raddr), .rdata(aux_rd)
	);

	lbsm_alu u_alu (.a(alu_a), .b(alu_b), .sum(alu_sum));

	assign pos_addr  = AW'(32'(pos_q));
	assign accept    = in_valid && in_ready;
	assign rd_en     = cnt_q != CNT_END;
	assign cfg_ready = 1'b1;
	assign mask_hit  = (tok_on_q && !aux_rd[1]) || (syn_on_q && !aux_rd[0]);
	// steering term: Q12.20 product, round half up, down to Q16.16
	assign term_raw  = (VAL_W+1)'(prod_q) + (VAL_W+1)'(8);

	always_comb begin
		need_clr = 1'b0;
		clr_d = '0;
		unique case (func_q)
			FN_LOGIT: begin
				need_clr = last_q;
				clr_d.pend = last_q;
			end
			FN_CLR_BIAS: begin
				need_clr = 1'b1;
				clr_d.pers = 1'b1;
				clr_d.pend = 1'b1;
			end
			FN_CLR_PEND: begin
				need_clr = 1'b1;
				clr_d.pend = 1'b1;
			end
			FN_CLR_STEER: begin
				need_clr = 1'b1;
				clr_d.steer = 1'b1;
			end
			FN_CLR_TOK: begin
				need_clr = 1'b1;
				clr_d.tok = 1'b1;
			end
			FN_CLR_SYN: begin
				need_clr = 1'b1;
				clr_d.syn = 1'b1;
			end
			default: begin
				need_clr = 1'b0;
			end
		endcase
	end

	assign fin_go = (state_q == ST_FIN) &&
		((func_q != FN_LOGIT) || !out_valid_q || out_ready);
	assign clr_start = fin_go && need_clr;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:  if (!rd_en && !wr_s1) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = ST_READ;
			ST_READ: state_d = ST_ADD1;
			ST_ADD1: state_d = ST_ADD2;
			ST_ADD2: state_d = ST_FIN;
			ST_FIN: begin
				if (fin_go) state_d = need_clr ? ST_CLR : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake, adder operands, memory controls
	always_comb begin
		in_ready  = state_q == ST_IDLE;
		alu_a     = acc_q;
		alu_b     = term_q;
		mem_re    = 1'b0;
		mem_raddr = pos_addr;
		mem_waddr = pos_addr;
		bias_we   = 1'b0;
		aux_we    = 1'b0;
		bias_wd   = bias_rd;
		aux_wd    = aux_rd;
		unique case (state_q)
			ST_CLR: begin
				mem_re    = rd_en;
				mem_raddr = cnt_q[AW-1:0];
				mem_waddr = addr_s1;
				bias_we   = wr_s1;
				aux_we    = wr_s1;
				bias_wd   = {clr_q.pers ? '0 : bias_rd[BIAS_W-1:VAL_W],
					clr_q.pend ? '0 : bias_rd[VAL_W-1:0]};
				aux_wd    = {clr_q.steer ? '0 : aux_rd[AUX_W-1:2],
					clr_q.tok ? 1'b0 : aux_rd[1], clr_q.syn ? 1'b0 : aux_rd[0]};
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_ADD1: begin
				alu_a = val_q;
				alu_b = (func_q == FN_PEND) ? bias_rd[VAL_W-1:0]
					: bias_rd[BIAS_W-1:VAL_W];
			end
			ST_ADD2: begin
				alu_b = bias_rd[VAL_W-1:0];
			end
			ST_FIN: begin
				if (fin_go && inr_q) begin
					priority case (func_q)
						FN_PERS: begin
							bias_we = 1'b1;
							bias_wd = {acc_q, bias_rd[VAL_W-1:0]};
						end
						FN_PEND: begin
							bias_we = 1'b1;
							bias_wd = {bias_rd[BIAS_W-1:VAL_W], acc_q};
						end
						FN_STEER: begin
							aux_we = 1'b1;
							aux_wd = {steer_q, aux_rd[1:0]};
						end
						FN_TOK: begin
							aux_we = 1'b1;
							aux_wd = {aux_rd[AUX_W-1:2], 1'b1, aux_rd[0]};
						end
						FN_SYN: begin
							aux_we = 1'b1;
							aux_wd = {aux_rd[AUX_W-1:1], 1'b1};
						end
						default: begin
							bias_we = 1'b0;
						end
					endcase
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// final logit value
	always_comb begin
		fin_val = hit_q ? alu_sum : acc_q;
		if (!inr_q) begin
			fin_val = val_q;
		end else if (mask_hit) begin
			fin_val = NEG_INF;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '1;
			cnt_q       <= '0;
			wr_s1       <= 1'b0;
			vocab_q     <= CFG_W'(32768);
			strength_q  <= '0;
			steer_len_q <= '0;
			steer_on_q  <= 1'b0;
			tok_on_q    <= 1'b0;
			syn_on_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_VOCAB:    vocab_q <= cfg_data;
					REG_STRENGTH: strength_q <= cfg_data;
					default:      vocab_q <= vocab_q;
				endcase
			end
			if (clr_start) begin
				clr_q <= clr_d;
				cnt_q <= '0;
				wr_s1 <= 1'b0;
			end else if (state_q == ST_CLR) begin
				wr_s1 <= rd_en;
				if (rd_en) cnt_q <= cnt_q + CW'(1);
			end
			if (fin_go && func_q == FN_LOGIT) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (fin_go) begin
				priority case (func_q)
					FN_STEER: begin
						steer_on_q <= 1'b1;
						if (inr_q && {1'b0, steer_len_q} < 17'(pos_q) + 17'd1) begin
							steer_len_q <= STEER_W'(pos_q) + STEER_W'(1);
						end
					end
					FN_CLR_STEER: begin
						steer_on_q  <= 1'b0;
						steer_len_q <= '0;
					end
					FN_TOK:     tok_on_q <= 1'b1;
					FN_CLR_TOK: tok_on_q <= 1'b0;
					FN_SYN:     syn_on_q <= 1'b1;
					FN_CLR_SYN: syn_on_q <= 1'b0;
					default:    tok_on_q <= tok_on_q;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			pos_q   <= position;
			val_q   <= item_value;
			steer_q <= steer_value;
			last_q  <= last_in;
			inr_q   <= ({1'b0, position} < vocab_q) && (32'(position) < VOCAB_DEPTH);
			hit_q   <= steer_on_q && ({1'b0, position} < steer_len_q);
		end
		if (state_q == ST_CLR) addr_s1 <= cnt_q[AW-1:0];
		if (state_q == ST_ADD1) begin
			acc_q  <= alu_sum;
			prod_q <= VAL_W'($signed(aux_rd[AUX_W-1:2])) * VAL_W'(strength_q);
		end
		if (state_q == ST_ADD2) begin
			if (func_q == FN_LOGIT) acc_q <= alu_sum;
			term_q <= VAL_W'(term_raw >>> 4);
		end
		if (fin_go && func_q == FN_LOGIT) begin
			position_out <= pos_q;
			logit_out    <= fin_val;
			masked_out   <= inr_q && mask_hit;
			last_out     <= last_q;
		end
	end

	assign out_valid = out_valid_q;

	`LBSM_ASSERT(a_no_accept_in_sweep, !(accept && state_q == ST_CLR))
	`LBSM_ASSERT_NEXT(a_accept_reads, accept, state_q == ST_READ)
	`LBSM_ASSERT(a_result_from_fin, $rose(out_valid) |-> $past(state_q == ST_FIN))
endmodule
`default_nettype wire
